// ===== src/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define THNM_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define THNM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/thnm_pkg.sv =====
package thnm_pkg;

   localparam int HISTORY_DEPTH_DEF = 64;
   localparam int STAMP_W           = 48;
   localparam int TAG_W             = 32;
   localparam int SLOT_OUT_W        = 6;
   localparam int CAP_W             = 7;
   localparam int MODE_W            = 2;
   localparam int CSR_AW            = 3;
   localparam int CSR_DW            = 32;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_FIND = 1'b1;

   localparam logic [MODE_W-1:0] MODE_EGO = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EXP = 2'd1;

   // register index taken from paddr[2]
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_EARLY = 3'd2,
      ST_LATE  = 3'd3,
      ST_MODE  = 3'd4
   } thnm_status_type;

   typedef struct packed {
      logic              func;
      logic [STAMP_W-1:0] stamp;
      logic [TAG_W-1:0]   ego_attitude_tag;
      logic [TAG_W-1:0]   exp_attitude_tag;
      logic [TAG_W-1:0]   rate_tag;
      logic [MODE_W-1:0]  est_mode;
   } thnm_req_type;

   typedef struct packed {
      thnm_status_type       status;
      logic [SLOT_OUT_W-1:0] match_slot;
      logic [TAG_W-1:0]      attitude_out_tag;
      logic [TAG_W-1:0]      rate_out_tag;
   } thnm_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_PUSH, S_FIND, S_BACK, S_ENDS, S_CHECK, S_MUL, S_DINIT, S_DIV,
      S_GUESS, S_G_RD, S_G_EV, S_F_RD, S_F_EV, S_B_RD, S_B_EV, S_TAG, S_OUT
   } thnm_state_type;

   typedef enum logic [1:0] {
      ADDR_FRONT, ADDR_BACK, ADDR_POS
   } thnm_addr_sel_type;

   typedef enum logic [2:0] {
      SLOT_POS, SLOT_POS_M1, SLOT_POS_P1, SLOT_LAST, SLOT_GUESS
   } thnm_slot_sel_type;

   typedef struct packed {
      logic              load;
      logic              push;
      logic              cap_front;
      logic              cap_back;
      logic              cap_diff;
      logic              mul;
      logic              div_init;
      logic              div_step;
      logic              set_guess;
      logic              set_prev;
      logic              pos_inc;
      logic              pos_dec;
      logic              set_slot;
      thnm_slot_sel_type slot_sel;
      thnm_addr_sel_type addr_sel;
      logic              fire;
      thnm_status_type   code;
   } thnm_cmd_type;

   typedef struct packed {
      logic empty;
      logic early;
      logic late;
      logic bad_mode;
      logic div_last;
      logic t_gt;
      logic t_lt;
      logic near;
      logic at_first;
      logic at_last;
   } thnm_stat_type;

endpackage

// ===== src/thnm_ram.sv =====
module thnm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/thnm_ctrl.sv =====
module thnm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_func,
   input  thnm_pkg::thnm_stat_type stat,
   output thnm_pkg::thnm_cmd_type  cmd,
   output logic                    busy
);

   thnm_pkg::thnm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= thnm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         thnm_pkg::S_IDLE: begin
            if (start) begin
               state_in = (req_func == thnm_pkg::FUNC_FIND) ? thnm_pkg::S_FIND
                                                             : thnm_pkg::S_PUSH;
            end
         end
         thnm_pkg::S_PUSH:  state_in = thnm_pkg::S_IDLE;
         thnm_pkg::S_FIND:  state_in = stat.empty ? thnm_pkg::S_IDLE : thnm_pkg::S_BACK;
         thnm_pkg::S_BACK:  state_in = thnm_pkg::S_ENDS;
         thnm_pkg::S_ENDS:  state_in = thnm_pkg::S_CHECK;
         thnm_pkg::S_CHECK: begin
            if (stat.early || stat.late || stat.bad_mode) begin
               state_in = thnm_pkg::S_IDLE;
            end else begin
               state_in = thnm_pkg::S_MUL;
            end
         end
         thnm_pkg::S_MUL:   state_in = thnm_pkg::S_DINIT;
         thnm_pkg::S_DINIT: state_in = thnm_pkg::S_DIV;
         thnm_pkg::S_DIV:   state_in = stat.div_last ? thnm_pkg::S_GUESS : thnm_pkg::S_DIV;
         thnm_pkg::S_GUESS: state_in = thnm_pkg::S_G_RD;
         thnm_pkg::S_G_RD:  state_in = thnm_pkg::S_G_EV;
         thnm_pkg::S_G_EV: begin
            if (stat.t_gt) begin
               state_in = stat.at_last ? thnm_pkg::S_TAG : thnm_pkg::S_F_RD;
            end else begin
               state_in = stat.at_first ? thnm_pkg::S_TAG : thnm_pkg::S_B_RD;
            end
         end
         thnm_pkg::S_F_RD:  state_in = thnm_pkg::S_F_EV;
         thnm_pkg::S_F_EV: begin
            if (stat.t_lt || stat.at_last) begin
               state_in = thnm_pkg::S_TAG;
            end else begin
               state_in = thnm_pkg::S_F_RD;
            end
         end
         thnm_pkg::S_B_RD:  state_in = thnm_pkg::S_B_EV;
         thnm_pkg::S_B_EV: begin
            if (stat.t_gt || stat.at_first) begin
               state_in = thnm_pkg::S_TAG;
            end else begin
               state_in = thnm_pkg::S_B_RD;
            end
         end
         thnm_pkg::S_TAG:   state_in = thnm_pkg::S_OUT;
         thnm_pkg::S_OUT:   state_in = thnm_pkg::S_IDLE;
         default:           state_in = thnm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.addr_sel = thnm_pkg::ADDR_POS;
      cmd.slot_sel = thnm_pkg::SLOT_POS;
      cmd.code     = thnm_pkg::ST_OK;
      unique case (state_ff)
         thnm_pkg::S_IDLE: cmd.load = start;
         thnm_pkg::S_PUSH: begin
            cmd.push = 1'b1;
            cmd.fire = 1'b1;
         end
         thnm_pkg::S_FIND: begin
            cmd.addr_sel = thnm_pkg::ADDR_FRONT;
            if (stat.empty) begin
               cmd.fire = 1'b1;
               cmd.code = thnm_pkg::ST_EMPTY;
            end
         end
         thnm_pkg::S_BACK: begin
            cmd.addr_sel  = thnm_pkg::ADDR_BACK;
            cmd.cap_front = 1'b1;
         end
         thnm_pkg::S_ENDS: cmd.cap_back = 1'b1;
         thnm_pkg::S_CHECK: begin
            cmd.cap_diff = 1'b1;
            priority if (stat.early) begin
               cmd.fire = 1'b1;
               cmd.code = thnm_pkg::ST_EARLY;
            end else if (stat.late) begin
               cmd.fire = 1'b1;
               cmd.code = thnm_pkg::ST_LATE;
            end else if (stat.bad_mode) begin
               cmd.fire = 1'b1;
               cmd.code = thnm_pkg::ST_MODE;
            end
         end
         thnm_pkg::S_MUL:   cmd.mul = 1'b1;
         thnm_pkg::S_DINIT: cmd.div_init = 1'b1;
         thnm_pkg::S_DIV:   cmd.div_step = 1'b1;
         thnm_pkg::S_GUESS: cmd.set_guess = 1'b1;
         thnm_pkg::S_G_EV: begin
            cmd.set_prev = 1'b1;
            if (stat.t_gt) begin
               if (stat.at_last) begin
                  cmd.set_slot = 1'b1;
                  cmd.slot_sel = thnm_pkg::SLOT_LAST;
               end else begin
                  cmd.pos_inc = 1'b1;
               end
            end else begin
               if (stat.at_first) begin
                  cmd.set_slot = 1'b1;
                  cmd.slot_sel = thnm_pkg::SLOT_GUESS;
               end else begin
                  cmd.pos_dec = 1'b1;
               end
            end
         end
         thnm_pkg::S_F_EV: begin
            if (stat.t_lt) begin
               cmd.set_slot = 1'b1;
               cmd.slot_sel = stat.near ? thnm_pkg::SLOT_POS : thnm_pkg::SLOT_POS_M1;
            end else begin
               cmd.set_prev = 1'b1;
               if (stat.at_last) begin
                  cmd.set_slot = 1'b1;
                  cmd.slot_sel = thnm_pkg::SLOT_LAST;
               end else begin
                  cmd.pos_inc = 1'b1;
               end
            end
         end
         thnm_pkg::S_B_EV: begin
            if (stat.t_gt) begin
               cmd.set_slot = 1'b1;
               cmd.slot_sel = stat.near ? thnm_pkg::SLOT_POS : thnm_pkg::SLOT_POS_P1;
            end else begin
               cmd.set_prev = 1'b1;
               if (stat.at_first) begin
                  cmd.set_slot = 1'b1;
                  cmd.slot_sel = thnm_pkg::SLOT_GUESS;
               end else begin
                  cmd.pos_dec = 1'b1;
               end
            end
         end
         thnm_pkg::S_OUT:  cmd.fire = 1'b1;
         default: begin
         end
      endcase
   end

   assign busy = (state_ff != thnm_pkg::S_IDLE);

endmodule

// ===== src/thnm_dpath.sv =====
module thnm_dpath #(
   parameter int HISTORY_DEPTH = thnm_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  thnm_pkg::thnm_req_type        req_data,
   input  logic [thnm_pkg::CAP_W-1:0]    capacity,
   input  thnm_pkg::thnm_cmd_type        cmd,
   output thnm_pkg::thnm_stat_type       stat,
   output logic                          rsp_valid,
   output thnm_pkg::thnm_rsp_type        rsp_data
);

   localparam int SW  = $clog2(HISTORY_DEPTH);
   localparam int CW  = $clog2(HISTORY_DEPTH + 1);
   localparam int LW  = ((CW > thnm_pkg::CAP_W) ? CW : thnm_pkg::CAP_W) + 1;
   localparam int STW = thnm_pkg::STAMP_W;
   localparam int TW  = thnm_pkg::TAG_W;
   localparam int PW  = SW + STW;
   localparam int DCW = $clog2(SW + 1);

   function automatic logic [SW-1:0] ring_pos(input logic [SW-1:0] base,
                                              input logic [SW-1:0] pos);
      logic [SW:0] sum;
      sum = {1'b0, base} + {1'b0, pos};
      if (sum >= (SW+1)'(HISTORY_DEPTH)) begin
         sum = sum - (SW+1)'(HISTORY_DEPTH);
      end
      return sum[SW-1:0];
   endfunction

   thnm_pkg::thnm_req_type req_ff, req_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [SW-1:0]  oldest_ff, oldest_in;
   logic [STW-1:0] front_ff, front_in, back_ff, back_in;
   logic [STW-1:0] diff_ff, diff_in, den_ff, den_in;
   logic [PW-1:0]  prod_ff, prod_in;
   logic [STW-1:0] rem_ff, rem_in;
   logic [SW-1:0]  lo_ff, lo_in, quo_ff, quo_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [SW-1:0]  pos_ff, pos_in, guess_ff, guess_in, slot_ff, slot_in;
   logic [STW-1:0] prev_ff, prev_in;
   logic           rsp_valid_ff, rsp_valid_in;
   thnm_pkg::thnm_rsp_type rsp_ff, rsp_in;

   logic [CW-1:0]   nm1;
   logic [SW-1:0]   last_pos, push_pos, rd_pos, quo_cl, slot_pick;
   logic [LW-1:0]   cap_x, dep_x, cap_eff, inc;
   logic            drop;
   logic [STW-1:0]  t, s, dist_s, dist_p;
   logic [STW:0]    trial, tdiff;
   logic            ge;
   logic [15:0]     slot_wide;
   logic [STW-1:0]  stamp_rdata;
   logic [3*TW-1:0] tag_rdata;

   assign t        = req_ff.stamp;
   assign s        = stamp_rdata;
   assign nm1      = count_ff - CW'(1);
   assign last_pos = nm1[SW-1:0];
   // a full ring writes over the oldest slot
   assign push_pos = (count_ff == CW'(HISTORY_DEPTH)) ? '0 : count_ff[SW-1:0];
   assign cap_x    = LW'(capacity);
   assign dep_x    = LW'(HISTORY_DEPTH);
   assign cap_eff  = (cap_x > dep_x) ? dep_x : cap_x;
   assign inc      = LW'(count_ff) + LW'(1);
   assign drop     = (inc > cap_eff);

   always_comb begin
      unique case (cmd.addr_sel)
         thnm_pkg::ADDR_FRONT: rd_pos = '0;
         thnm_pkg::ADDR_BACK:  rd_pos = last_pos;
         default:              rd_pos = pos_ff;
      endcase
   end

   thnm_ram #(.WIDTH(STW), .DEPTH(HISTORY_DEPTH)) u_stamp_ram (
      .clock (clock),
      .we    (cmd.push),
      .waddr (ring_pos(oldest_ff, push_pos)),
      .wdata (req_ff.stamp),
      .raddr (ring_pos(oldest_ff, rd_pos)),
      .rdata (stamp_rdata)
   );

   thnm_ram #(.WIDTH(3*TW), .DEPTH(HISTORY_DEPTH)) u_tag_ram (
      .clock (clock),
      .we    (cmd.push),
      .waddr (ring_pos(oldest_ff, push_pos)),
      .wdata ({req_ff.ego_attitude_tag, req_ff.exp_attitude_tag, req_ff.rate_tag}),
      .raddr (ring_pos(oldest_ff, slot_ff)),
      .rdata (tag_rdata)
   );

   assign dist_s = (t > s) ? (t - s) : (s - t);
   assign dist_p = (t > prev_ff) ? (t - prev_ff) : (prev_ff - t);

   // restoring divide, one quotient bit per cycle
   assign trial = {rem_ff, lo_ff[SW-1]};
   assign tdiff = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   assign quo_cl = (quo_ff > last_pos) ? last_pos : quo_ff;

   always_comb begin
      unique case (cmd.slot_sel)
         thnm_pkg::SLOT_POS_M1: slot_pick = pos_ff - SW'(1);
         thnm_pkg::SLOT_POS_P1: slot_pick = pos_ff + SW'(1);
         thnm_pkg::SLOT_LAST:   slot_pick = last_pos;
         thnm_pkg::SLOT_GUESS:  slot_pick = guess_ff;
         default:               slot_pick = pos_ff;
      endcase
   end

   assign slot_wide = 16'(slot_ff);

   always_comb begin
      req_in       = cmd.load ? req_data : req_ff;
      count_in     = count_ff;
      oldest_in    = oldest_ff;
      front_in     = cmd.cap_front ? s : front_ff;
      back_in      = cmd.cap_back ? s : back_ff;
      diff_in      = cmd.cap_diff ? (t - front_ff) : diff_ff;
      den_in       = cmd.cap_diff ? (back_ff - front_ff) : den_ff;
      prod_in      = cmd.mul ? (PW'(diff_ff) * PW'(last_pos)) : prod_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      pos_in       = pos_ff;
      guess_in     = guess_ff;
      slot_in      = cmd.set_slot ? slot_pick : slot_ff;
      prev_in      = cmd.set_prev ? s : prev_ff;
      rsp_valid_in = cmd.fire;
      rsp_in       = rsp_ff;

      if (cmd.push) begin
         if (drop) begin
            oldest_in = ring_pos(oldest_ff, SW'(1));
         end else begin
            count_in = inc[CW-1:0];
         end
      end
      if (cmd.div_init) begin
         rem_in  = prod_ff[PW-1:SW];
         lo_in   = prod_ff[SW-1:0];
         quo_in  = '0;
         dcnt_in = DCW'(SW - 1);
      end else if (cmd.div_step) begin
         rem_in  = ge ? tdiff[STW-1:0] : trial[STW-1:0];
         lo_in   = lo_ff << 1;
         quo_in  = SW'({quo_ff, ge});
         dcnt_in = dcnt_ff - DCW'(1);
      end
      if (cmd.set_guess) begin
         // equal end stamps guess the oldest slot
         guess_in = (front_ff == back_ff) ? '0 : quo_cl;
         pos_in   = (front_ff == back_ff) ? '0 : quo_cl;
      end else if (cmd.pos_inc) begin
         pos_in = pos_ff + SW'(1);
      end else if (cmd.pos_dec) begin
         pos_in = pos_ff - SW'(1);
      end
      if (cmd.fire) begin
         rsp_in        = '0;
         rsp_in.status = cmd.code;
         if (cmd.code == thnm_pkg::ST_OK && req_ff.func == thnm_pkg::FUNC_FIND) begin
            rsp_in.match_slot       = slot_wide[thnm_pkg::SLOT_OUT_W-1:0];
            rsp_in.attitude_out_tag = (req_ff.est_mode == thnm_pkg::MODE_EGO)
                                      ? tag_rdata[3*TW-1:2*TW] : tag_rdata[2*TW-1:TW];
            rsp_in.rate_out_tag     = tag_rdata[TW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      front_ff <= front_in;
      back_ff  <= back_in;
      diff_ff  <= diff_in;
      den_ff   <= den_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      lo_ff    <= lo_in;
      quo_ff   <= quo_in;
      dcnt_ff  <= dcnt_in;
      pos_ff   <= pos_in;
      guess_ff <= guess_in;
      slot_ff  <= slot_in;
      prev_ff  <= prev_in;
      rsp_ff   <= rsp_in;
   end

   assign stat.empty    = (count_ff == '0);
   assign stat.early    = (t < front_ff);
   assign stat.late     = (t > back_ff);
   assign stat.bad_mode = (req_ff.est_mode != thnm_pkg::MODE_EGO) &&
                          (req_ff.est_mode != thnm_pkg::MODE_EXP);
   assign stat.div_last = (dcnt_ff == '0);
   assign stat.t_gt     = (t > s);
   assign stat.t_lt     = (t < s);
   assign stat.near     = (dist_s < dist_p);
   assign stat.at_first = (pos_ff == '0);
   assign stat.at_last  = (pos_ff == last_pos);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/timestamp_history_nearest_match.sv =====
// Timestamped history with nearest-stamp lookup. An item is taken when start is high and
// busy is low; exactly one result follows, shown for one cycle with rsp_valid, and cannot
// be held off. A push writes the entry and answers; a find that fails a check answers
// without a divide. A successful find divides for a slot guess, the divider yielding one
// quotient bit per cycle, then walks from the guess, each step a registered read of the
// stamp memory followed by a compare. The user writes Capacity (register 0) through the
// APB port only while idle; the block itself does not enforce it. Values above
// HISTORY_DEPTH act as HISTORY_DEPTH. Stored contents need no clearing.
`include "assert_macros.svh"

module timestamp_history_nearest_match #(
   parameter int HISTORY_DEPTH = thnm_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  thnm_pkg::thnm_req_type        req_data,
   output logic                          rsp_valid,
   output thnm_pkg::thnm_rsp_type        rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [thnm_pkg::CSR_AW-1:0]   paddr,
   input  logic [thnm_pkg::CSR_DW-1:0]   pwdata,
   output logic [thnm_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   logic [thnm_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic                       cap_sel;
   thnm_pkg::thnm_cmd_type     cmd;
   thnm_pkg::thnm_stat_type    stat;
   logic                       rsp_err_clean;

   assign pready  = 1'b1;
   assign cap_sel = (paddr[2] == thnm_pkg::REG_CAPACITY);
   assign cap_in  = (psel && penable && pwrite && cap_sel)
                    ? pwdata[thnm_pkg::CAP_W-1:0] : cap_ff;
   assign prdata  = cap_sel ? thnm_pkg::CSR_DW'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
      end else begin
         cap_ff <= cap_in;
      end
   end

   thnm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_data.func),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   thnm_dpath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .capacity  (cap_ff),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_err_clean = (rsp_data.match_slot == '0) && (rsp_data.attitude_out_tag == '0)
                          && (rsp_data.rate_out_tag == '0);

   `THNM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
   `THNM_ASSERT_IMPLY(a_rsp_after_busy, rsp_valid, $past(busy), "result without work")
   `THNM_ASSERT_NEXT(a_single_beat, rsp_valid, !rsp_valid, "result beat repeated")
   `THNM_ASSERT_IMPLY(a_err_zero, rsp_valid && rsp_data.status != thnm_pkg::ST_OK, rsp_err_clean, "error result carries data")

endmodule
